FILE: design/wmf5_pkg.sv
// Package for the 5x5 RGB window mode filter.
// It holds the pixel, window and status types that all the filter modules share.
`default_nettype none
package wmf5_pkg;
   localparam int WIN        = 5;
   localparam int WIN_SIZE   = WIN * WIN;
   localparam int LINES      = 4;
   localparam int EDGE       = 2;
   localparam int CNT_W      = 5;
   localparam int KEY_W      = CNT_W + 8;
   localparam int MAX_HEIGHT = 4096;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   typedef logic [23:0] pix_type;
   typedef pix_type [LINES-1:0] line_col_type;
   typedef logic [WIN_SIZE-1:0][7:0] chan_win_type;

   typedef struct packed {
      logic [10:0] col;
      logic [11:0] row;
      logic        last;
   } meta_type;
endpackage
`default_nettype wire

FILE: design/wmf5_line_store.sv
// Line store of the window mode filter: four lines of pixels per column in one memory.
// It depends on wmf5_pkg for the column type.
`default_nettype none
module wmf5_line_store
   import wmf5_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              advance,
   input  wire logic [$clog2(MAX_LINE_WIDTH)-1:0] rd_addr,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(MAX_LINE_WIDTH)-1:0] wr_addr,
   input  wire line_col_type                      wr_data,
   output line_col_type                           rd_data
);
   line_col_type mem [MAX_LINE_WIDTH];
   line_col_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (advance) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: design/wmf5_mode_unit.sv
// Four-stage mode unit for one color channel of the 5x5 window.
// It depends on wmf5_pkg for the window and key sizes.
`default_nettype none
module wmf5_mode_unit
   import wmf5_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         advance,
   input  wire chan_win_type win_in,
   output logic [7:0]        mode_out
);
   logic [WIN_SIZE-1:0][WIN_SIZE-1:0] eq_ff, eq_in;
   chan_win_type                      val_a_ff, val_b_ff;
   logic [WIN_SIZE-1:0][CNT_W-1:0]    cnt_ff, cnt_in;
   logic [WIN-1:0][KEY_W-1:0]         grp_ff, grp_in;
   logic [7:0]                        mode_ff, mode_in;

   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         for (int j = 0; j < WIN_SIZE; j++) begin
            eq_in[i][j] = (win_in[i] == win_in[j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         cnt_in[i] = CNT_W'($countones(eq_ff[i]));
      end
   end

   always_comb begin
      logic [KEY_W-1:0] key;
      for (int g = 0; g < WIN; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < WIN; k++) begin
            key = {cnt_ff[g*WIN+k], ~val_b_ff[g*WIN+k]};
            if (key > grp_in[g]) begin
               grp_in[g] = key;
            end
         end
      end
   end

   always_comb begin
      logic [KEY_W-1:0] best;
      best = '0;
      for (int g = 0; g < WIN; g++) begin
         if (grp_ff[g] > best) begin
            best = grp_ff[g];
         end
      end
      mode_in = ~best[7:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         eq_ff    <= eq_in;
         val_a_ff <= win_in;
         cnt_ff   <= cnt_in;
         val_b_ff <= val_a_ff;
         grp_ff   <= grp_in;
         mode_ff  <= mode_in;
      end
   end

   assign mode_out = mode_ff;
endmodule
`default_nettype wire

FILE: design/window_mode_filter_5x5_rgb_unit.sv
// Top level of the 5x5 RGB window mode filter: position counters, line store, window, mode units.
// It depends on wmf5_pkg, wmf5_line_store and wmf5_mode_unit.
`default_nettype none
// The filter takes one RGB pixel per clock in raster order and gives one result per clock for
// every pixel whose full 5x5 neighborhood lies inside the frame; border pixels two wide give no
// result. A result passes through these registers after the request that completes its window
// is accepted: the accepting edge starts the line store read, the window register then loads,
// and the four mode pipeline stages follow, the last of which is the output register.
// Only a stall on the result side slows intake, and then the whole pipeline holds. Writing
// either size register restarts the frame at column 0, row 0.
module window_mode_filter_5x5_rgb_unit
   import wmf5_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [12:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [10:0]      rsp_out_col,
   output logic [11:0]      rsp_out_row,
   output logic             rsp_frame_end
);
   localparam int CW = $clog2(MAX_LINE_WIDTH);

   logic [11:0]   width_ff;
   logic [12:0]   height_ff;
   logic [CW-1:0] col_ff, col_in, col_last;
   logic [11:0]   row_ff, row_in, row_last;
   logic          advance, accept;

   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [11:0]   s1_row_ff;
   pix_type       s1_pix_ff;

   line_col_type  rd_data, wr_data;
   pix_type [WIN-1:0][WIN-1:0] window_ff;
   logic [3:0]    pipe_valid_ff;
   meta_type      meta_ff [4];
   meta_type      meta_in;
   logic          rsp_valid_ff;
   meta_type      rsp_meta_ff;
   chan_win_type  win_r, win_g, win_b;
   logic [13:0]   col_off;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   always_comb begin
      if (width_ff < 12'd5) begin
         col_last = CW'(4);
      end else if (32'(width_ff) > MAX_LINE_WIDTH) begin
         col_last = CW'(MAX_LINE_WIDTH - 1);
      end else begin
         col_last = CW'(width_ff - 12'd1);
      end
      if (height_ff < 13'd5) begin
         row_last = 12'd4;
      end else if (height_ff > 13'(MAX_HEIGHT)) begin
         row_last = 12'(MAX_HEIGHT - 1);
      end else begin
         row_last = 12'(height_ff - 13'd1);
      end
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 13'd480;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == REG_WIDTH) begin
            width_ff <= csr_write_data[11:0];
         end else begin
            height_ff <= csr_write_data;
         end
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   wmf5_line_store #(
      .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .advance(advance),
      .rd_addr(col_ff),
      .wr_en  (advance && s1_valid_ff),
      .wr_addr(s1_col_ff),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   always_comb begin
      wr_data = rd_data;
      wr_data[s1_row_ff[1:0]] = s1_pix_ff;
      col_off = 14'(s1_col_ff) - 14'(EDGE);
      meta_in.col  = col_off[10:0];
      meta_in.row  = s1_row_ff - 12'(EDGE);
      meta_in.last = (s1_col_ff == col_last) && (s1_row_ff == row_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         pipe_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         window_ff     <= '0;
      end else if (advance) begin
         s1_valid_ff   <= accept;
         pipe_valid_ff <= {pipe_valid_ff[2:0],
                           s1_valid_ff && s1_col_ff >= CW'(4) && s1_row_ff >= 12'd4};
         rsp_valid_ff  <= pipe_valid_ff[3];
         if (s1_valid_ff) begin
            for (int c = 0; c < WIN - 1; c++) begin
               window_ff[c] <= window_ff[c+1];
            end
            for (int k = 0; k < LINES; k++) begin
               window_ff[WIN-1][k] <= rd_data[2'(s1_row_ff[1:0] + 2'(k))];
            end
            window_ff[WIN-1][LINES] <= s1_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_pix_ff   <= {req_blue, req_green, req_red};
         meta_ff[0]  <= meta_in;
         for (int i = 1; i < 4; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
         rsp_meta_ff <= meta_ff[3];
      end
   end

   always_comb begin
      for (int c = 0; c < WIN; c++) begin
         for (int r = 0; r < WIN; r++) begin
            win_r[c*WIN+r] = window_ff[c][r][7:0];
            win_g[c*WIN+r] = window_ff[c][r][15:8];
            win_b[c*WIN+r] = window_ff[c][r][23:16];
         end
      end
   end

   wmf5_mode_unit u_mode_red (
      .clock(clock), .advance(advance), .win_in(win_r), .mode_out(rsp_out_red)
   );
   wmf5_mode_unit u_mode_green (
      .clock(clock), .advance(advance), .win_in(win_g), .mode_out(rsp_out_green)
   );
   wmf5_mode_unit u_mode_blue (
      .clock(clock), .advance(advance), .win_in(win_b), .mode_out(rsp_out_blue)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_col   = rsp_meta_ff.col;
   assign rsp_out_row   = rsp_meta_ff.row;
   assign rsp_frame_end = rsp_meta_ff.last;
endmodule
`default_nettype wire

FILE: design/wmf5_checker.sv
// Port checker for the 5x5 RGB window mode filter, bound to its top level.
// It depends only on the ports of window_mode_filter_5x5_rgb_unit.
`default_nettype none
module wmf5_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        req_stall,
   input wire logic [10:0] rsp_out_col,
   input wire logic [11:0] rsp_out_row,
   input wire logic [7:0]  rsp_out_red
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_col) && $stable(rsp_out_red))
      else $error("stalled result changed");

   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_col >= 11'd2 && rsp_out_row >= 12'd2)
      else $error("result outside the interior");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without result backpressure");
endmodule

bind window_mode_filter_5x5_rgb_unit wmf5_checker u_wmf5_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .req_stall(req_stall), .rsp_out_col(rsp_out_col), .rsp_out_row(rsp_out_row),
   .rsp_out_red(rsp_out_red)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for window_mode_filter_5x5_rgb_unit; it needs only the RTL and wmf5_pkg.
// A behavioral predictor of the 5x5 window mode filter gives the expected results,
// which are checked against every accepted response.
`timescale 1ns / 1ps
module tb_top;
   import wmf5_pkg::*;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [10:0] col;
      logic [11:0] row;
      logic        last;
   } mode_result_type;

   localparam int LINE_MAX      = 2048;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = REG_WIDTH;
   logic [12:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [10:0] rsp_out_col;
   logic [11:0] rsp_out_row;
   logic        rsp_frame_end;

   logic [23:0] line_mem [LINES][LINE_MAX];
   logic [23:0] window [WIN][WIN];
   int unsigned next_col;
   int unsigned next_row;
   logic [11:0] frame_width;
   logic [12:0] frame_height;

   mode_result_type pending_results[$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   bit  idling_on = 1'b0;
   int  pixels_sent = 0;

   window_mode_filter_5x5_rgb_unit dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_out_col(rsp_out_col),
      .rsp_out_row(rsp_out_row), .rsp_frame_end(rsp_frame_end)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned active_width();
      if (frame_width < WIN) return WIN;
      if (frame_width > LINE_MAX) return LINE_MAX;
      return frame_width;
   endfunction

   function automatic int unsigned active_height();
      if (frame_height < WIN) return WIN;
      if (frame_height > MAX_HEIGHT) return MAX_HEIGHT;
      return frame_height;
   endfunction

   function automatic logic [7:0] channel_mode(int shift);
      int hist [256];
      int best_count;
      logic [7:0] best;
      foreach (hist[v]) hist[v] = 0;
      for (int c = 0; c < WIN; c++)
         for (int r = 0; r < WIN; r++)
            hist[(window[c][r] >> shift) & 8'hFF]++;
      best = 8'd0;
      best_count = 0;
      for (int v = 0; v < 256; v++) begin
         if (hist[v] > best_count) begin
            best_count = hist[v];
            best = v[7:0];
         end
      end
      return best;
   endfunction

   task automatic predict_window_mode(logic [23:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      mode_result_type res;
      w = active_width();
      h = active_height();
      col = (next_col >= w) ? 0 : next_col;
      row = (next_row >= h) ? 0 : next_row;
      for (int c = 0; c < WIN - 1; c++)
         for (int k = 0; k < WIN; k++)
            window[c][k] = window[c + 1][k];
      for (int k = 0; k < LINES; k++)
         window[WIN - 1][k] = line_mem[(row + k) % LINES][col];
      window[WIN - 1][LINES] = pix;
      line_mem[row % LINES][col] = pix;
      if (col >= WIN - 1 && row >= WIN - 1) begin
         res.red   = channel_mode(0);
         res.green = channel_mode(8);
         res.blue  = channel_mode(16);
         res.col   = 11'(col - EDGE);
         res.row   = 12'(row - EDGE);
         res.last  = (col == w - 1 && row == h - 1);
         pending_results.push_back(res);
      end
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      next_col = col;
      next_row = row;
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while (idling_on && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_window_mode({b, g, r});
      pixels_sent++;
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(logic [0:0] index, logic [12:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      if (index == REG_WIDTH) frame_width = value[11:0];
      else frame_height = value;
      next_col = 0;
      next_row = 0;
   endtask

   task automatic set_frame(int w, int h);
      write_size(REG_WIDTH, 13'(w));
      write_size(REG_HEIGHT, 13'(h));
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_pixels(int count, int palette);
      for (int i = 0; i < count; i++) begin
         if (palette == 0)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
         else
            send_pixel(8'($urandom_range(palette)), 8'($urandom_range(palette) * 85),
                       8'(255 - $urandom_range(palette)));
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= idling_on && ($urandom_range(99) < 18);
   end

   always @(posedge clock) begin
      mode_result_type got;
      mode_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_col, rsp_out_row,
                rsp_frame_end};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result: rgb %0d %0d %0d col %0d row %0d last %0b",
                        got.red, got.green, got.blue, got.col, got.row, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected rgb %0d %0d %0d col %0d row %0d last %0b, %s",
                           want.red, want.green, want.blue, want.col, want.row, want.last,
                           $sformatf("got rgb %0d %0d %0d col %0d row %0d last %0b",
                                     got.red, got.green, got.blue, got.col, got.row,
                                     got.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_reset_size();
      send_random_pixels(100, 0);
      end_burst();
   endtask

   task automatic test_flat_frames();
      set_frame(5, 5);
      for (int i = 0; i < 25; i++) send_pixel(8'h00, 8'hFF, 8'h00);
      for (int i = 0; i < 25; i++) send_pixel(8'hFF, 8'h00, 8'hFF);
      end_burst();
   endtask

   task automatic test_ties_small_palette();
      set_frame(7, 6);
      send_random_pixels(7 * 6 * 3, 1);
      end_burst();
   endtask

   task automatic test_clamped_low();
      set_frame(0, 4);
      send_random_pixels(30, 2);
      end_burst();
      set_frame($urandom_range(4), $urandom_range(4));
      send_random_pixels(25, 0);
      end_burst();
   endtask

   task automatic test_large_frames();
      idling_on = 1'b0;
      set_frame(4095, 5);
      send_random_pixels(40, 3);
      end_burst();
      set_frame(2048, 4096);
      send_random_pixels(40, 0);
      end_burst();
      set_frame(5, 8191);
      send_random_pixels(5 * 60, 2);
      end_burst();
      idling_on = 1'b1;
   endtask

   task automatic test_random_frames();
      int start;
      start = pixels_sent;
      while (pixels_sent - start < 1200) begin
         set_frame($urandom_range(5, 12), $urandom_range(5, 9));
         if ($urandom_range(3) == 0)
            send_random_pixels($urandom_range(1, 60), 0);
         else
            send_random_pixels(active_width() * active_height() * $urandom_range(1, 2),
                               $urandom_range(1, 3) * ($urandom_range(1) ? 1 : 0));
         end_burst();
      end
   endtask

   initial begin
      frame_width  = 12'd640;
      frame_height = 13'd480;
      next_col = 0;
      next_row = 0;
      foreach (window[c, r]) window[c][r] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idling_on = 1'b1;
      test_reset_size();
      test_flat_frames();
      test_ties_small_palette();
      test_clamped_low();
      test_large_frames();
      test_random_frames();
      end_burst();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
